// ----- rtl/zx0_pkg.sv -----
// Shared types and constants for the ZX0 stream decompressor.
package zx0_pkg;
	localparam int unsigned HistDepthDefault = 32768;

	localparam logic [3:0] PH_LIT_CTL    = 4'd0;
	localparam logic [3:0] PH_LIT_DAT    = 4'd1;
	localparam logic [3:0] PH_LIT_COPY   = 4'd2;
	localparam logic [3:0] PH_SEL_LIT    = 4'd3;
	localparam logic [3:0] PH_REP_CTL    = 4'd4;
	localparam logic [3:0] PH_REP_DAT    = 4'd5;
	localparam logic [3:0] PH_REP_COPY   = 4'd6;
	localparam logic [3:0] PH_SEL_COPY   = 4'd7;
	localparam logic [3:0] PH_OFF_CTL    = 4'd8;
	localparam logic [3:0] PH_OFF_DAT    = 4'd9;
	localparam logic [3:0] PH_OFF_LO     = 4'd10;
	localparam logic [3:0] PH_LEN_CTL    = 4'd11;
	localparam logic [3:0] PH_LEN_DAT    = 4'd12;
	localparam logic [3:0] PH_MATCH_COPY = 4'd13;
	localparam logic [3:0] PH_DONE       = 4'd14;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_FINISHED   = 3'd1;
	localparam logic [2:0] ST_BAD_OFFSET = 3'd2;
	localparam logic [2:0] ST_OVERFLOW   = 3'd3;
	localparam logic [2:0] ST_TRAILING   = 3'd4;
	localparam logic [2:0] ST_MISUSE     = 3'd5;
	localparam logic [2:0] ST_TRUNCATED  = 3'd6;

	typedef struct packed {
		logic       mode;
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       want;
		logic [2:0] status;
	} out_item_t;
endpackage

// ----- rtl/zx0_if.sv -----
// Valid/ready stream interface carrying one item.
interface zx0_if #(parameter type item_t = logic) ();
	logic  valid;
	logic  ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/zx0_stream_decompressor.sv -----
// ZX0 decompressor top level: bit parser, history memory and result register.
// Each item is accepted only in idle. A byte item is then parsed one bit per cycle and
// its result registered; a pull item first reads history, then parses and registers.
// A failed decoder skips parsing and goes straight to the result register.
// One item at a time: the next is accepted only once the last result is registered,
// which waits while the result register is full. Reset clears control state; history is garbage.
module zx0_stream_decompressor #(
	parameter int unsigned HISTORY_DEPTH = zx0_pkg::HistDepthDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	zx0_if.sink   in_ch,
	zx0_if.source out_ch
);
	import zx0_pkg::*;

	localparam int unsigned AW = $clog2(HISTORY_DEPTH);
	localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_PARSE = 2'd1;
	localparam logic [1:0] S_READ  = 2'd2;
	localparam logic [1:0] S_OUT   = 2'd3;

	logic [7:0] hist_mem [HISTORY_DEPTH];
	logic [7:0] rd_data_q;
	logic       wr_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [7:0] wr_data;

	logic [1:0]  state_q;
	logic        classic_q;
	logic [CW-1:0] wcount_q;
	logic [7:0]  group_q;
	logic [3:0]  bitpos_q;
	logic        reuse_q, saved_q;
	logic [CW-1:0] prev_off_q;
	logic [3:0]  phase_q;
	logic [CW+1:0] gacc_q;
	logic [CW:0] remain_q;
	logic        ended_q;
	logic [2:0]  status_q;
	logic        ovalid_q;
	out_item_t   res_q;
	logic        emit_v_q;
	logic [7:0]  emit_b_q;

	logic is_copy, needs_byte;
	assign is_copy    = (phase_q == PH_REP_COPY) || (phase_q == PH_MATCH_COPY);
	assign needs_byte = !is_copy && (phase_q != PH_DONE);

	// result register may be refilled when empty or taken this cycle
	logic out_free;
	assign out_free = !ovalid_q || out_ch.ready;

	assign in_ch.ready   = (state_q == S_IDLE);
	assign out_ch.valid  = ovalid_q;
	assign out_ch.data   = res_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			hist_mem[wr_addr] <= wr_data;
		rd_data_q <= hist_mem[rd_addr];
	end

	// parse step signals
	logic bit_avail, cur_bit, parse_stop;
	logic [CW+1:0] gacc_grow;
	assign bit_avail = reuse_q || (bitpos_q != 4'd0);
	assign cur_bit   = reuse_q ? saved_q : group_q[7];
	assign parse_stop = (status_q != ST_OK) || !needs_byte || (phase_q == PH_LIT_COPY)
		|| (phase_q == PH_OFF_LO) || !bit_avail;

	logic [CW:0] pull_idx;
	assign pull_idx = {1'b0, wcount_q} - {1'b0, prev_off_q};

	logic in_acc;
	assign in_acc = in_ch.valid && in_ch.ready;

	// literal byte written straight into history
	logic lit_wr;
	assign lit_wr = in_acc && !in_ch.data.mode && status_q <= ST_FINISHED
		&& phase_q == PH_LIT_COPY && !ended_q && wcount_q < CW'(HISTORY_DEPTH);

	logic [CW+8:0] off_full;
	assign off_full = {gacc_q, 7'd0} - {{(CW+2){1'b0}}, in_ch.data.in_byte[7:1]};

	always_comb begin
		wr_en   = lit_wr;
		wr_addr = wcount_q[AW-1:0];
		wr_data = in_ch.data.in_byte;
		rd_addr = pull_idx[AW-1:0];
		gacc_grow = {gacc_q[CW:0], 1'b0};
		if (state_q == S_READ) begin
			wr_en   = (wcount_q < CW'(HISTORY_DEPTH));
			wr_data = rd_data_q;
		end
		if (phase_q == PH_OFF_DAT)
			gacc_grow[0] = cur_bit ^ !classic_q;
		else
			gacc_grow[0] = cur_bit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			classic_q  <= 1'b0;
			wcount_q   <= '0;
			group_q    <= '0;
			bitpos_q   <= '0;
			reuse_q    <= 1'b0;
			saved_q    <= 1'b0;
			prev_off_q <= CW'(1);
			phase_q    <= PH_LIT_CTL;
			gacc_q     <= (CW+2)'(1);
			remain_q   <= '0;
			ended_q    <= 1'b0;
			status_q   <= ST_OK;
			ovalid_q   <= 1'b0;
			res_q      <= '0;
			emit_v_q   <= 1'b0;
			emit_b_q   <= '0;
		end else begin
			if (cfg_we)
				classic_q <= cfg_wdata;
			if (state_q == S_OUT && out_free)
				ovalid_q <= 1'b1;
			else if (out_ch.valid && out_ch.ready)
				ovalid_q <= 1'b0;
			case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					emit_v_q <= lit_wr;
					emit_b_q <= lit_wr ? in_ch.data.in_byte : 8'd0;
					if (status_q > ST_FINISHED) begin
						state_q <= S_OUT;
					end else if (!in_ch.data.mode) begin
						state_q <= S_PARSE;
						if (phase_q == PH_DONE || ended_q)
							status_q <= ST_TRAILING;
						else if (is_copy)
							status_q <= ST_MISUSE;
						else begin
							if (in_ch.data.in_last)
								ended_q <= 1'b1;
							if (phase_q == PH_LIT_COPY) begin
								if (wcount_q >= CW'(HISTORY_DEPTH))
									status_q <= ST_OVERFLOW;
								else begin
									wcount_q <= wcount_q + 1'b1;
									remain_q <= remain_q - 1'b1;
									if (remain_q == (CW+1)'(1))
										phase_q <= PH_SEL_LIT;
								end
							end else if (phase_q == PH_OFF_LO) begin
								if (off_full > (CW+9)'(wcount_q))
									status_q <= ST_BAD_OFFSET;
								else begin
									prev_off_q <= off_full[CW-1:0];
									reuse_q    <= 1'b1;
									saved_q    <= in_ch.data.in_byte[0];
									gacc_q     <= (CW+2)'(1);
									phase_q    <= PH_LEN_CTL;
								end
							end else begin
								group_q  <= in_ch.data.in_byte;
								bitpos_q <= 4'd8;
							end
						end
					end else begin
						if (phase_q == PH_DONE)
							state_q <= S_PARSE;
						else if (!is_copy) begin
							status_q <= ST_MISUSE;
							state_q  <= S_PARSE;
						end else if (prev_off_q > wcount_q
							|| pull_idx >= (CW+1)'(HISTORY_DEPTH)) begin
							status_q <= ST_BAD_OFFSET;
							state_q  <= S_PARSE;
						end else
							state_q <= S_READ;
					end
				end
			end
			S_READ: begin
				if (wcount_q >= CW'(HISTORY_DEPTH))
					status_q <= ST_OVERFLOW;
				else begin
					wcount_q <= wcount_q + 1'b1;
					emit_v_q <= 1'b1;
					emit_b_q <= rd_data_q;
					remain_q <= remain_q - 1'b1;
					if (remain_q == (CW+1)'(1))
						phase_q <= PH_SEL_COPY;
				end
				state_q <= S_PARSE;
			end
			S_PARSE: begin
				if (parse_stop) begin
					if (status_q == ST_OK && ended_q && needs_byte)
						status_q <= ST_TRUNCATED;
					state_q <= S_OUT;
				end else begin
					// consume one bit
					if (reuse_q)
						reuse_q <= 1'b0;
					else begin
						group_q  <= {group_q[6:0], 1'b0};
						bitpos_q <= bitpos_q - 1'b1;
					end
					case (phase_q)
					PH_LIT_CTL: begin
						if (cur_bit) begin
							remain_q <= gacc_q[CW:0];
							phase_q  <= PH_LIT_COPY;
						end else phase_q <= PH_LIT_DAT;
					end
					PH_SEL_LIT: begin
						gacc_q  <= (CW+2)'(1);
						phase_q <= cur_bit ? PH_OFF_CTL : PH_REP_CTL;
					end
					PH_REP_CTL: begin
						if (cur_bit) begin
							remain_q <= gacc_q[CW:0];
							if (prev_off_q > wcount_q)
								status_q <= ST_BAD_OFFSET;
							phase_q <= PH_REP_COPY;
						end else phase_q <= PH_REP_DAT;
					end
					PH_SEL_COPY: begin
						gacc_q  <= (CW+2)'(1);
						phase_q <= cur_bit ? PH_OFF_CTL : PH_LIT_CTL;
					end
					PH_OFF_CTL: begin
						if (cur_bit) begin
							if (gacc_q == (CW+2)'(256)) begin
								phase_q  <= PH_DONE;
								status_q <= ended_q ? ST_FINISHED : ST_TRAILING;
							end else phase_q <= PH_OFF_LO;
						end else phase_q <= PH_OFF_DAT;
					end
					PH_OFF_DAT: begin
						gacc_q  <= gacc_grow;
						if (gacc_grow > (CW+2)'(256))
							status_q <= ST_BAD_OFFSET;
						phase_q <= PH_OFF_CTL;
					end
					PH_LEN_CTL: begin
						if (cur_bit) begin
							remain_q <= gacc_q[CW:0] + 1'b1;
							phase_q  <= PH_MATCH_COPY;
						end else phase_q <= PH_LEN_DAT;
					end
					default: begin
						// LIT_DAT, REP_DAT and LEN_DAT grow the length
						gacc_q <= gacc_grow;
						if (gacc_grow > (CW+2)'(HISTORY_DEPTH))
							status_q <= ST_OVERFLOW;
						if (phase_q == PH_LIT_DAT)
							phase_q <= PH_LIT_CTL;
						else if (phase_q == PH_REP_DAT)
							phase_q <= PH_REP_CTL;
						else
							phase_q <= PH_LEN_CTL;
					end
					endcase
				end
			end
			default: begin
				// hold the result until the register is free
				if (out_free) begin
					res_q.out_byte  <= emit_b_q;
					res_q.out_valid <= emit_v_q;
					res_q.want      <= (status_q == ST_OK) && is_copy;
					res_q.status    <= status_q;
					state_q         <= S_IDLE;
				end
			end
			endcase
		end
	end

	// The write count never exceeds the history depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		wcount_q <= CW'(HISTORY_DEPTH))
		else $error("write count beyond history depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> is_copy)
		else $error("history read outside a copy");
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (wcount_q < CW'(HISTORY_DEPTH)))
		else $error("history write when full");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free) |=> (ovalid_q && state_q == S_IDLE))
		else $error("result not registered");
endmodule

// ----- dv/tb_zx0_stream_decompressor.sv -----
// Testbench for the ZX0 stream decompressor: encoded stream stimulus, predictor and checker.
`timescale 1ns / 1ps

module tb_zx0_stream_decompressor;
	import zx0_pkg::*;

	localparam int unsigned HIST       = HistDepthDefault;
	localparam int unsigned HIST_AW    = $clog2(HIST);
	localparam int unsigned CYCLE_CAP  = 600000;
	localparam int unsigned END_MARK   = 256;
	localparam int unsigned HOLD_LEN   = 200;

	typedef enum logic [1:0] {
		TK_LIT,
		TK_COPY
	} tok_class_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	zx0_if #(.item_t(in_item_t))  in_ch ();
	zx0_if #(.item_t(out_item_t)) out_ch ();

	zx0_stream_decompressor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// Decoder mirror
	logic [7:0]  hist_m [HIST];
	logic [15:0] m_written;
	logic [7:0]  m_grp;
	logic [3:0]  m_bitpos;
	logic        m_reuse;
	logic        m_saved;
	logic [15:0] m_prev_off;
	logic [3:0]  m_phase;
	logic [16:0] m_acc;
	logic [15:0] m_remain;
	logic        m_ended;
	logic [2:0]  m_status;
	logic        m_classic;

	out_item_t   exp_q [$];
	int unsigned mismatches;
	int unsigned cycles;
	int unsigned src_pct;
	int unsigned snk_pct;
	bit          snk_hold;

	// Encoded stream and classic-mode switch points (in decoded bytes)
	logic [7:0]  enc [$];
	int          enc_grp_idx;
	int unsigned enc_mask;
	int          enc_lsb_idx;
	int unsigned enc_w;
	bit          enc_first;
	tok_class_t  enc_prev;
	bit          enc_cls;
	int unsigned seg_bound [$];
	bit          seg_flag [$];
	int          seg_next;
	int          enc_pos;

	function automatic bit m_in_copy();
		return m_phase == PH_REP_COPY || m_phase == PH_MATCH_COPY;
	endfunction

	function automatic bit m_needs_byte();
		return !m_in_copy() && m_phase != PH_DONE;
	endfunction

	function automatic void m_grow(bit b, int unsigned limit, logic [2:0] err);
		m_acc = {m_acc[15:0], b};
		if (m_acc > limit)
			m_status = err;
	endfunction

	function automatic void m_reset();
		m_written  = '0;
		m_grp      = '0;
		m_bitpos   = '0;
		m_reuse    = 1'b0;
		m_saved    = 1'b0;
		m_prev_off = 16'd1;
		m_phase    = PH_LIT_CTL;
		m_acc      = 17'd1;
		m_remain   = '0;
		m_ended    = 1'b0;
		m_status   = ST_OK;
		m_classic  = 1'b0;
	endfunction

	function automatic void m_parse();
		bit b;
		while (m_status == ST_OK && m_needs_byte() && m_phase != PH_LIT_COPY &&
				m_phase != PH_OFF_LO) begin
			if (m_reuse) begin
				m_reuse = 1'b0;
				b = m_saved;
			end else if (m_bitpos == 0) begin
				break;
			end else begin
				b = m_grp[7];
				m_grp = m_grp << 1;
				m_bitpos = m_bitpos - 1;
			end
			case (m_phase)
				PH_LIT_CTL: begin
					if (b) begin
						m_remain = m_acc[15:0];
						m_phase = PH_LIT_COPY;
					end else m_phase = PH_LIT_DAT;
				end
				PH_LIT_DAT: begin
					m_grow(b, HIST, ST_OVERFLOW);
					m_phase = PH_LIT_CTL;
				end
				PH_SEL_LIT: begin
					m_acc = 17'd1;
					m_phase = b ? PH_OFF_CTL : PH_REP_CTL;
				end
				PH_REP_CTL: begin
					if (b) begin
						m_remain = m_acc[15:0];
						if (m_prev_off > m_written)
							m_status = ST_BAD_OFFSET;
						m_phase = PH_REP_COPY;
					end else m_phase = PH_REP_DAT;
				end
				PH_REP_DAT: begin
					m_grow(b, HIST, ST_OVERFLOW);
					m_phase = PH_REP_CTL;
				end
				PH_SEL_COPY: begin
					m_acc = 17'd1;
					m_phase = b ? PH_OFF_CTL : PH_LIT_CTL;
				end
				PH_OFF_CTL: begin
					if (b) begin
						if (m_acc == END_MARK) begin
							m_phase = PH_DONE;
							m_status = m_ended ? ST_FINISHED : ST_TRAILING;
						end else m_phase = PH_OFF_LO;
					end else m_phase = PH_OFF_DAT;
				end
				PH_OFF_DAT: begin
					m_grow(b ^ !m_classic, END_MARK, ST_BAD_OFFSET);
					m_phase = PH_OFF_CTL;
				end
				PH_LEN_CTL: begin
					if (b) begin
						m_remain = m_acc[15:0] + 16'd1;
						m_phase = PH_MATCH_COPY;
					end else m_phase = PH_LEN_DAT;
				end
				default: begin
					m_grow(b, HIST, ST_OVERFLOW);
					m_phase = PH_LEN_CTL;
				end
			endcase
		end
	endfunction

	function automatic bit m_emit(logic [7:0] v, inout out_item_t r);
		if (m_written >= HIST) begin
			m_status = ST_OVERFLOW;
			return 1'b0;
		end
		hist_m[m_written[HIST_AW-1:0]] = v;
		m_written = m_written + 1;
		r.out_byte = v;
		r.out_valid = 1'b1;
		return 1'b1;
	endfunction

	function automatic void m_byte(logic [7:0] v, logic last, inout out_item_t r);
		int unsigned off;
		if (m_phase == PH_DONE || m_ended) begin
			m_status = ST_TRAILING;
			return;
		end
		if (m_in_copy()) begin
			m_status = ST_MISUSE;
			return;
		end
		if (last)
			m_ended = 1'b1;
		if (m_phase == PH_LIT_COPY) begin
			if (!m_emit(v, r))
				return;
			m_remain = m_remain - 1;
			if (m_remain == 0)
				m_phase = PH_SEL_LIT;
		end else if (m_phase == PH_OFF_LO) begin
			off = m_acc * 128 - (v >> 1);
			if (off > m_written) begin
				m_status = ST_BAD_OFFSET;
				return;
			end
			m_prev_off = off[15:0];
			m_reuse = 1'b1;
			m_saved = v[0];
			m_acc = 17'd1;
			m_phase = PH_LEN_CTL;
		end else begin
			m_grp = v;
			m_bitpos = 4'd8;
		end
	endfunction

	function automatic void m_pull(inout out_item_t r);
		int unsigned idx;
		if (m_phase == PH_DONE)
			return;
		if (!m_in_copy()) begin
			m_status = ST_MISUSE;
			return;
		end
		idx = m_written - m_prev_off;
		if (m_prev_off > m_written || idx >= HIST) begin
			m_status = ST_BAD_OFFSET;
			return;
		end
		if (!m_emit(hist_m[idx[HIST_AW-1:0]], r))
			return;
		m_remain = m_remain - 1;
		if (m_remain == 0)
			m_phase = PH_SEL_COPY;
	endfunction

	function automatic out_item_t decode_step(in_item_t it);
		out_item_t r;
		r = '0;
		if (m_status == ST_OK || m_status == ST_FINISHED) begin
			if (!it.mode)
				m_byte(it.in_byte, it.in_last, r);
			else
				m_pull(r);
			m_parse();
			if (m_status == ST_OK && m_ended && m_needs_byte())
				m_status = ST_TRUNCATED;
		end
		r.want = (m_status == ST_OK) && m_in_copy();
		r.status = m_status;
		return r;
	endfunction

	// Stream encoder
	function automatic void put_bit(bit b);
		if (enc_lsb_idx >= 0) begin
			enc[enc_lsb_idx][0] = b;
			enc_lsb_idx = -1;
			return;
		end
		if (enc_mask == 0) begin
			enc_mask = 128;
			enc_grp_idx = enc.size();
			enc.push_back(8'h00);
		end
		if (b)
			enc[enc_grp_idx] = enc[enc_grp_idx] | 8'(enc_mask);
		enc_mask = enc_mask >> 1;
	endfunction

	function automatic void put_gamma(int unsigned v, bit inv);
		int msb;
		msb = 0;
		while ((v >> (msb + 1)) != 0)
			msb++;
		for (int i = msb - 1; i >= 0; i--) begin
			put_bit(1'b0);
			put_bit(((v >> i) & 1) ^ inv);
		end
		put_bit(1'b1);
	endfunction

	function automatic void add_literal(int unsigned len, int fixed);
		if (!enc_first)
			put_bit(1'b0);
		enc_first = 1'b0;
		put_gamma(len, 1'b0);
		for (int i = 0; i < len; i++)
			enc.push_back(fixed < 0 ? 8'($urandom_range(255)) : 8'(fixed));
		enc_w += len;
		enc_prev = TK_LIT;
	endfunction

	function automatic void add_rep(int unsigned len);
		put_bit(1'b0);
		put_gamma(len, 1'b0);
		enc_w += len;
		enc_prev = TK_COPY;
	endfunction

	function automatic void add_match(int unsigned off, int unsigned len);
		int unsigned hi;
		hi = (off - 1) / 128 + 1;
		put_bit(1'b1);
		put_gamma(hi, !enc_cls);
		enc.push_back(8'((hi * 128 - off) << 1));
		// the first length bit rides in the low bit of the offset byte
		enc_lsb_idx = enc.size() - 1;
		put_gamma(len - 1, 1'b0);
		enc_w += len;
		enc_prev = TK_COPY;
	endfunction

	function automatic void switch_classic();
		enc_cls = !enc_cls;
		seg_bound.push_back(enc_w);
		seg_flag.push_back(enc_cls);
	endfunction

	function automatic void build_stream(bit start_cls);
		int unsigned next_switch;
		int unsigned off;
		enc.delete();
		enc_mask = 0;
		enc_lsb_idx = -1;
		enc_w = 0;
		enc_first = 1'b1;
		enc_cls = start_cls;
		seg_next = 0;
		enc_pos = 0;
		// extremes of byte values, offset one, the largest offset and repeats
		add_literal(1, 8'h00);
		add_rep(1);
		add_literal(2, 8'hFF);
		add_match(1, 2);
		add_literal(1, 8'h80);
		add_match(enc_w, 3);
		add_literal(3, 8'h7F);
		add_rep(2);
		add_match(2, 2);
		add_literal(2, 8'h55);
		next_switch = 300;
		while (enc_w < 1750) begin
			if (enc_w >= next_switch) begin
				switch_classic();
				next_switch += 300;
			end
			case ($urandom_range(2))
				0: off = $urandom_range(1, enc_w < 4 ? enc_w : 4);
				1: off = $urandom_range(1, enc_w);
				default: off = enc_w;
			endcase
			if (enc_prev == TK_LIT) begin
				if ($urandom_range(99) < 30)
					add_rep($urandom_range(1, 10));
				else
					add_match(off, $urandom_range(99) < 10 ? $urandom_range(2, 40) :
						$urandom_range(2, 10));
			end else if ($urandom_range(99) < 60) begin
				add_literal($urandom_range(99) < 5 ? $urandom_range(1, 60) :
					$urandom_range(1, 8), -1);
			end else begin
				add_match(off, $urandom_range(2, 12));
			end
		end
		put_bit(1'b1);
		put_gamma(END_MARK, !enc_cls);
	endfunction

	// Checker
	always @(posedge clk) begin : check_results
		out_item_t want_r;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (exp_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: %p", out_ch.data);
			end else begin
				want_r = exp_q.pop_front();
				if (out_ch.data.out_byte !== want_r.out_byte ||
						out_ch.data.out_valid !== want_r.out_valid ||
						out_ch.data.want !== want_r.want ||
						out_ch.data.status !== want_r.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected byte %h valid %b want %b status %0d, got byte %h valid %b want %b status %0d",
							want_r.out_byte, want_r.out_valid, want_r.want, want_r.status,
							out_ch.data.out_byte, out_ch.data.out_valid, out_ch.data.want,
							out_ch.data.status);
				end
			end
		end
	end

	always @(posedge clk)
		out_ch.ready <= !snk_hold && ($urandom_range(99) >= snk_pct);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic send_item(in_item_t it);
		while ($urandom_range(99) < src_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= it;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		exp_q.push_back(decode_step(it));
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (exp_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_classic(bit v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		m_classic = v;
	endtask

	task automatic send_stream(int unsigned max_items);
		in_item_t it;
		for (int unsigned n = 0; n < max_items && m_phase != PH_DONE; n++) begin
			// switch mode while the last copy of a segment stalls the parser
			if (seg_next < seg_bound.size() && m_written == seg_bound[seg_next] - 1 &&
					(m_in_copy() || m_phase == PH_LIT_COPY)) begin
				write_classic(seg_flag[seg_next]);
				seg_next++;
			end
			if (m_in_copy()) begin
				it.mode    = 1'b1;
				it.in_byte = 8'($urandom_range(255));
				it.in_last = 1'($urandom_range(1));
			end else begin
				if (enc_pos >= enc.size())
					break;
				it.mode    = 1'b0;
				it.in_byte = enc[enc_pos];
				it.in_last = (enc_pos == enc.size() - 1);
				enc_pos++;
			end
			send_item(it);
		end
	endtask

	task automatic test_config_writes(bit start_cls);
		write_classic(1'b1);
		write_classic(1'b0);
		write_classic(start_cls);
	endtask

	task automatic test_directed();
		src_pct = 0;
		snk_pct = 0;
		send_stream(25);
	endtask

	task automatic test_no_idle();
		src_pct = 0;
		snk_pct = 0;
		send_stream(300);
	endtask

	task automatic test_sender_idle();
		src_pct = 48;
		snk_pct = 0;
		send_stream(300);
	endtask

	task automatic test_receiver_stall();
		src_pct = 0;
		snk_pct = 48;
		send_stream(300);
	endtask

	task automatic test_both_idle();
		src_pct = 25;
		snk_pct = 25;
		send_stream(300);
	endtask

	task automatic test_backpressure();
		src_pct = 0;
		snk_pct = 0;
		fork
			begin
				snk_hold = 1'b1;
				repeat (HOLD_LEN) @(posedge clk);
				snk_hold = 1'b0;
			end
		join_none
		send_stream(150);
	endtask

	task automatic test_finish();
		src_pct = 25;
		snk_pct = 25;
		send_stream(32'hFFFF_FFFF);
	endtask

	task automatic test_after_finish();
		in_item_t it;
		src_pct = 10;
		snk_pct = 10;
		// pull on a finished decoder does nothing
		it = '{mode: 1'b1, in_byte: 8'h00, in_last: 1'b0};
		send_item(it);
		// byte past the end sticks as trailing data
		it = '{mode: 1'b0, in_byte: 8'hFF, in_last: 1'b1};
		send_item(it);
		repeat (20) begin
			it.mode    = 1'($urandom_range(1));
			it.in_byte = 8'($urandom_range(255));
			it.in_last = 1'($urandom_range(1));
			send_item(it);
		end
	endtask

	initial begin
		bit start_cls;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.data    = '0;
		out_ch.ready  = 1'b0;
		mismatches    = 0;
		cycles        = 0;
		src_pct       = 0;
		snk_pct       = 0;
		snk_hold      = 1'b0;
		m_reset();
		start_cls = 1'($urandom_range(1));
		build_stream(start_cls);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_config_writes(start_cls);
		test_directed();
		test_no_idle();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		test_backpressure();
		test_finish();
		test_after_finish();

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && exp_q.size() == 0 && m_status == ST_TRAILING)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
